// ===== sv/ffca_pkg.sv =====
// ffca_pkg: shared types and constants of the first-fit cell allocator
// no dependencies; imported by the interfaces, ffca_seq and the core
package ffca_pkg;

   localparam int CODE_W  = 8;
   localparam int VALUE_W = 32;
   localparam int FUNC_W  = 2;
   localparam int ADDR_W  = 8;
   localparam int COUNT_W = 9;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   typedef struct packed {
      logic                      status;
      logic [ADDR_W-1:0]         start_address;
      logic [CODE_W-1:0]         read_code;
      logic signed [VALUE_W-1:0] read_value;
   } res_type;

endpackage

// ===== sv/ffca_req_if.sv =====
// ffca_req_if: request channel of the allocator, valid/ready with payload
// depends on ffca_pkg for field widths
interface ffca_req_if import ffca_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic [CODE_W-1:0]         ins_code;
   logic signed [VALUE_W-1:0] ins_value;
   logic                      is_last;
   logic [ADDR_W-1:0]         free_start;
   logic [COUNT_W-1:0]        free_count;

   modport source (
      output valid, func, ins_code, ins_value, is_last, free_start, free_count,
      input  ready
   );
   modport sink (
      input  valid, func, ins_code, ins_value, is_last, free_start, free_count,
      output ready
   );
endinterface

// ===== sv/ffca_rsp_if.sv =====
// ffca_rsp_if: response channel of the allocator, valid/ready with payload
// depends on ffca_pkg for field widths
interface ffca_rsp_if import ffca_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      status;
   logic [ADDR_W-1:0]         start_address;
   logic [CODE_W-1:0]         read_code;
   logic signed [VALUE_W-1:0] read_value;

   modport source (
      output valid, status, start_address, read_code, read_value,
      input  ready
   );
   modport sink (
      input  valid, status, start_address, read_code, read_value,
      output ready
   );
endinterface

// ===== sv/ffca_ram.sv =====
// ffca_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ffca_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/ffca_seq.sv =====
// ffca_seq: allocator sequencer - staging, first-fit scan, copy, free and read
// depends on ffca_pkg, ffca_req_if; drives the cell and staging rams
module ffca_seq import ffca_pkg::*; #(
   parameter int CELLS = 256
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [CODE_W-1:0]         empty_code,
   ffca_req_if.sink                  req,
   input  logic                      out_free,
   output logic                      res_load,
   output res_type                   res,
   output logic                      cell_we,
   output logic [$clog2(CELLS)-1:0]  cell_waddr,
   output logic [CODE_W-1:0]         cell_wcode,
   output logic [VALUE_W-1:0]        cell_wvalue,
   output logic                      cell_re,
   output logic [$clog2(CELLS)-1:0]  cell_raddr,
   input  logic [CODE_W-1:0]         cell_rcode,
   input  logic [VALUE_W-1:0]        cell_rvalue,
   output logic                      stg_we,
   output logic [$clog2(CELLS)-1:0]  stg_waddr,
   output logic [CODE_W-1:0]         stg_wcode,
   output logic [VALUE_W-1:0]        stg_wvalue,
   output logic                      stg_re,
   output logic [$clog2(CELLS)-1:0]  stg_raddr,
   input  logic [CODE_W-1:0]         stg_rcode,
   input  logic [VALUE_W-1:0]        stg_rvalue
);

   localparam int AW = $clog2(CELLS);
   localparam int CW = $clog2(CELLS + 1);
   localparam int SW = (CW > COUNT_W + 1) ? CW : COUNT_W + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FREE,
      S_SCAN,
      S_COPY,
      S_DONE,
      S_READ
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      staged_count_ff, staged_count_in;
   logic [CW-1:0]      len_ff, len_in;
   logic [SW-1:0]      ptr_ff, ptr_in;
   logic [SW-1:0]      end_ff, end_in;
   logic [CODE_W-1:0]  fill_code_ff, fill_code_in;
   logic [CW-1:0]      scan_addr_ff, scan_addr_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [AW-1:0]      chk_addr_ff, chk_addr_in;
   logic [CW-1:0]      run_ff, run_in;
   logic [AW-1:0]      first_ff, first_in;
   logic [AW-1:0]      start_ff, start_in;
   logic [CW-1:0]      cp_rd_ff, cp_rd_in;
   logic               cp_wv_ff, cp_wv_in;
   logic [AW-1:0]      cp_wa_ff, cp_wa_in;
   logic               rd_hit_ff, rd_hit_in;
   logic               res_status_ff, res_status_in;

   logic               accept;
   logic [SW-1:0]      free_sum;
   logic [SW-1:0]      free_end;
   logic [CW-1:0]      staged_next;
   logic [SW-1:0]      ptr_inc;
   logic [CW-1:0]      run_inc;
   logic [AW-1:0]      first_sel;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;

   assign free_sum    = SW'(req.free_start) + SW'(req.free_count);
   assign free_end    = (free_sum > SW'(CELLS)) ? SW'(CELLS) : free_sum;
   assign staged_next = (staged_count_ff < CW'(CELLS)) ? staged_count_ff + 1'b1
                                                        : staged_count_ff;
   assign ptr_inc     = ptr_ff + 1'b1;
   assign run_inc     = run_ff + 1'b1;
   assign first_sel   = (run_ff == '0) ? chk_addr_ff : first_ff;

   always_comb begin
      state_in        = state_ff;
      staged_count_in = staged_count_ff;
      len_in          = len_ff;
      ptr_in          = ptr_ff;
      end_in          = end_ff;
      fill_code_in    = fill_code_ff;
      scan_addr_in    = scan_addr_ff;
      chk_valid_in    = chk_valid_ff;
      chk_addr_in     = chk_addr_ff;
      run_in          = run_ff;
      first_in        = first_ff;
      start_in        = start_ff;
      cp_rd_in        = cp_rd_ff;
      cp_wv_in        = cp_wv_ff;
      cp_wa_in        = cp_wa_ff;
      rd_hit_in       = rd_hit_ff;
      res_status_in   = res_status_ff;

      res_load    = 1'b0;
      res         = '0;
      cell_we     = 1'b0;
      cell_waddr  = '0;
      cell_wcode  = '0;
      cell_wvalue = '0;
      cell_re     = 1'b0;
      cell_raddr  = '0;
      stg_we      = 1'b0;
      stg_waddr   = AW'(staged_count_ff);
      stg_wcode   = req.ins_code;
      stg_wvalue  = req.ins_value;
      stg_re      = 1'b0;
      stg_raddr   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req.func)
                  FUNC_ALLOC: begin
                     stg_we = (staged_count_ff < CW'(CELLS));
                     if (req.is_last) begin
                        len_in          = staged_next;
                        staged_count_in = '0;
                        scan_addr_in    = '0;
                        chk_valid_in    = 1'b0;
                        run_in          = '0;
                        first_in        = '0;
                        state_in        = S_SCAN;
                     end else begin
                        staged_count_in = staged_next;
                     end
                  end
                  FUNC_FREE: begin
                     if (SW'(req.free_start) < free_end) begin
                        ptr_in       = SW'(req.free_start);
                        end_in       = free_end;
                        fill_code_in = empty_code;
                        state_in     = S_FREE;
                     end
                  end
                  FUNC_READ: begin
                     rd_hit_in  = (SW'(req.free_start) < SW'(CELLS));
                     cell_re    = rd_hit_in;
                     cell_raddr = AW'(req.free_start);
                     state_in   = S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_FREE: begin
            cell_we    = 1'b1;
            cell_waddr = AW'(ptr_ff);
            cell_wcode = fill_code_ff;
            ptr_in     = ptr_inc;
            if (ptr_inc == end_ff) begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            if (scan_addr_ff < CW'(CELLS)) begin
               cell_re      = 1'b1;
               cell_raddr   = AW'(scan_addr_ff);
               scan_addr_in = scan_addr_ff + 1'b1;
               chk_valid_in = 1'b1;
               chk_addr_in  = AW'(scan_addr_ff);
            end else begin
               chk_valid_in = 1'b0;
            end
            if (chk_valid_ff) begin
               if (cell_rcode == empty_code) begin
                  run_in   = run_inc;
                  first_in = first_sel;
                  if (run_inc == len_ff) begin
                     start_in = first_sel;
                     cp_rd_in = '0;
                     cp_wv_in = 1'b0;
                     state_in = S_COPY;
                  end
               end else begin
                  run_in = '0;
               end
            end else if (scan_addr_ff == CW'(CELLS)) begin
               res_status_in = STATUS_NO_SPACE;
               start_in      = '0;
               state_in      = S_DONE;
            end
         end
         S_COPY: begin
            if (cp_rd_ff < len_ff) begin
               stg_re    = 1'b1;
               stg_raddr = AW'(cp_rd_ff);
               cp_rd_in  = cp_rd_ff + 1'b1;
               cp_wv_in  = 1'b1;
               cp_wa_in  = start_ff + AW'(cp_rd_ff);
            end else begin
               cp_wv_in = 1'b0;
            end
            if (cp_wv_ff) begin
               cell_we     = 1'b1;
               cell_waddr  = cp_wa_ff;
               cell_wcode  = stg_rcode;
               cell_wvalue = stg_rvalue;
            end
            if (cp_rd_ff == len_ff && !cp_wv_ff) begin
               res_status_in = STATUS_OK;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               res_load          = 1'b1;
               res.status        = res_status_ff;
               res.start_address = ADDR_W'(start_ff);
               state_in          = S_IDLE;
            end
         end
         S_READ: begin
            if (out_free) begin
               res_load       = 1'b1;
               res.status     = STATUS_OK;
               res.read_code  = rd_hit_ff ? cell_rcode : empty_code;
               res.read_value = rd_hit_ff ? cell_rvalue : '0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_FREE;
         staged_count_ff <= '0;
         ptr_ff          <= '0;
         end_ff          <= SW'(CELLS);
         fill_code_ff    <= '0;
         chk_valid_ff    <= 1'b0;
         cp_wv_ff        <= 1'b0;
      end else begin
         state_ff        <= state_in;
         staged_count_ff <= staged_count_in;
         ptr_ff          <= ptr_in;
         end_ff          <= end_in;
         fill_code_ff    <= fill_code_in;
         chk_valid_ff    <= chk_valid_in;
         cp_wv_ff        <= cp_wv_in;
      end
      len_ff        <= len_in;
      scan_addr_ff  <= scan_addr_in;
      chk_addr_ff   <= chk_addr_in;
      run_ff        <= run_in;
      first_ff      <= first_in;
      start_ff      <= start_in;
      cp_rd_ff      <= cp_rd_in;
      cp_wa_ff      <= cp_wa_in;
      rd_hit_ff     <= rd_hit_in;
      res_status_ff <= res_status_in;
   end

   a_no_cell_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(cell_we && cell_re))
      else $error("cell ram read and write in the same cycle");

   a_staged_bound: assert property (@(posedge clock) disable iff (reset)
      staged_count_ff <= CW'(CELLS))
      else $error("staged count beyond capacity");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      res_load |-> out_free)
      else $error("result loaded while output register is full");

   a_last_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (accept && req.func == FUNC_ALLOC && req.is_last) |=> (state_ff == S_SCAN))
      else $error("last alloc beat did not start a scan");

endmodule

// ===== sv/first_fit_cell_allocator_core.sv =====
// first_fit_cell_allocator_core: top level of the first-fit cell allocator
// depends on ffca_pkg, ffca_req_if, ffca_rsp_if, ffca_ram, ffca_seq
//
//   channel   direction  handshake          beat
//   req_bus   in         valid/ready        func, ins_code, ins_value, is_last,
//                                           free_start, free_count
//   rsp_bus   out        valid/ready        status, start_address, read_code,
//                                           read_value
//   csr_*     in         write enable only  empty_code
//
// alloc beat that is not last: staged, and the next beat is taken; last alloc
// beat: first-fit scan over the cell ram (one cell per cycle), then a copy from
// the staging ram, then the result is posted; free: one cell written per cycle;
// read: the addressed cell is read, the result posted. after reset a clearing
// pass writes every cell before the first beat is taken; csr writes are taken anytime.
// a stalled response sits in the output register; the next beat is still taken.
module first_fit_cell_allocator_core import ffca_pkg::*; #(
   parameter int CELLS = 256
) (
   input  logic              clock,
   input  logic              reset,
   ffca_req_if.sink          req_bus,
   ffca_rsp_if.source        rsp_bus,
   input  logic              csr_write_en,
   input  logic [CODE_W-1:0] csr_write_data
);

   localparam int AW = $clog2(CELLS);
   localparam int DW = CODE_W + VALUE_W;

   logic [CODE_W-1:0]  empty_code_ff;
   logic               rsp_valid_ff;
   res_type            rsp_data_ff;

   logic               out_free;
   logic               res_load;
   res_type            res;

   logic               cell_we, cell_re;
   logic [AW-1:0]      cell_waddr, cell_raddr;
   logic [CODE_W-1:0]  cell_wcode, cell_rcode;
   logic [VALUE_W-1:0] cell_wvalue, cell_rvalue;
   logic [DW-1:0]      cell_rdata;

   logic               stg_we, stg_re;
   logic [AW-1:0]      stg_waddr, stg_raddr;
   logic [CODE_W-1:0]  stg_wcode, stg_rcode;
   logic [VALUE_W-1:0] stg_wvalue, stg_rvalue;
   logic [DW-1:0]      stg_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_code_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write_en) begin
            empty_code_ff <= csr_write_data;
         end
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (res_load) begin
         rsp_data_ff <= res;
      end
   end

   assign out_free              = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_data_ff.status;
   assign rsp_bus.start_address = rsp_data_ff.start_address;
   assign rsp_bus.read_code     = rsp_data_ff.read_code;
   assign rsp_bus.read_value    = rsp_data_ff.read_value;

   assign cell_rcode  = cell_rdata[DW-1 -: CODE_W];
   assign cell_rvalue = cell_rdata[VALUE_W-1:0];
   assign stg_rcode   = stg_rdata[DW-1 -: CODE_W];
   assign stg_rvalue  = stg_rdata[VALUE_W-1:0];

   ffca_ram #(
      .WIDTH (DW),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock (clock),
      .we    (cell_we),
      .waddr (cell_waddr),
      .wdata ({cell_wcode, cell_wvalue}),
      .re    (cell_re),
      .raddr (cell_raddr),
      .rdata (cell_rdata)
   );

   ffca_ram #(
      .WIDTH (DW),
      .DEPTH (CELLS)
   ) u_stage_ram (
      .clock (clock),
      .we    (stg_we),
      .waddr (stg_waddr),
      .wdata ({stg_wcode, stg_wvalue}),
      .re    (stg_re),
      .raddr (stg_raddr),
      .rdata (stg_rdata)
   );

   ffca_seq #(
      .CELLS (CELLS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .empty_code  (empty_code_ff),
      .req         (req_bus),
      .out_free    (out_free),
      .res_load    (res_load),
      .res         (res),
      .cell_we     (cell_we),
      .cell_waddr  (cell_waddr),
      .cell_wcode  (cell_wcode),
      .cell_wvalue (cell_wvalue),
      .cell_re     (cell_re),
      .cell_raddr  (cell_raddr),
      .cell_rcode  (cell_rcode),
      .cell_rvalue (cell_rvalue),
      .stg_we      (stg_we),
      .stg_waddr   (stg_waddr),
      .stg_wcode   (stg_wcode),
      .stg_wvalue  (stg_wvalue),
      .stg_re      (stg_re),
      .stg_raddr   (stg_raddr),
      .stg_rcode   (stg_rcode),
      .stg_rvalue  (stg_rvalue)
   );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// testbench: self-checking bench for first_fit_cell_allocator_core, with a cell image
// predictor, directed table and random request streams; needs ffca_pkg, ffca_req_if, ffca_rsp_if
module testbench;
   import ffca_pkg::*;

   localparam int CELLS         = 256;
   localparam int SETTLE_CYCLES = 600;
   localparam int IDLE_LIMIT    = 5000;
   localparam int PHASES        = 5;
   localparam int PHASE_ITEMS   = 55;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic [CODE_W-1:0]         ins_code;
      logic signed [VALUE_W-1:0] ins_value;
      logic                      is_last;
      logic [ADDR_W-1:0]         free_start;
      logic [COUNT_W-1:0]        free_count;
   } req_beat_type;

   typedef struct packed {
      req_beat_type beat;
      logic [9:0]   lead;
      logic         typed;
      res_type      want;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic [CODE_W-1:0] csr_write_data;

   ffca_req_if req_bus ();
   ffca_rsp_if rsp_bus ();

   first_fit_cell_allocator_core #(.CELLS(CELLS)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   // cell image kept by the predictor
   logic [CODE_W-1:0]         img_code    [CELLS];
   logic signed [VALUE_W-1:0] img_value   [CELLS];
   logic [CODE_W-1:0]         stage_code  [CELLS];
   logic signed [VALUE_W-1:0] stage_value [CELLS];
   int                        stage_len;
   logic [CODE_W-1:0]         model_empty;
   logic [ADDR_W-1:0]         last_grant;

   res_type      rsp_backlog [$];
   stim_row_type directed_rows [$];
   res_type      got_rsp;
   res_type      want_rsp;

   bit no_idle;
   int beats_sent;
   int rsp_checked;
   int grants;
   int no_space;
   int settings;
   int mismatch_count;
   int idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic cell_image_step(input req_beat_type b, output bit owed, output res_type r);
      int run;
      int first;
      int stop;
      int len;
      bit found;
      owed = 1'b0;
      r = '0;
      case (b.func)
         FUNC_ALLOC: begin
            if (stage_len < CELLS) begin
               stage_code[stage_len] = b.ins_code;
               stage_value[stage_len] = b.ins_value;
               stage_len++;
            end
            if (b.is_last) begin
               len = stage_len;
               stage_len = 0;
               run = 0;
               first = 0;
               found = 1'b0;
               for (int i = 0; i < CELLS && !found; i++) begin
                  if (img_code[i] == model_empty) begin
                     if (run == 0) first = i;
                     run++;
                     if (run == len) found = 1'b1;
                  end else begin
                     run = 0;
                  end
               end
               owed = 1'b1;
               if (found) begin
                  for (int j = 0; j < len; j++) begin
                     img_code[first + j] = stage_code[j];
                     img_value[first + j] = stage_value[j];
                  end
                  r.status = STATUS_OK;
                  r.start_address = first[ADDR_W-1:0];
                  last_grant = first[ADDR_W-1:0];
                  grants++;
               end else begin
                  r.status = STATUS_NO_SPACE;
                  no_space++;
               end
            end
         end
         FUNC_FREE: begin
            stop = int'(b.free_start) + int'(b.free_count);
            if (stop > CELLS) stop = CELLS;
            for (int i = int'(b.free_start); i < stop; i++) begin
               img_code[i] = model_empty;
               img_value[i] = '0;
            end
         end
         FUNC_READ: begin
            owed = 1'b1;
            r.status = STATUS_OK;
            r.read_code = img_code[b.free_start];
            r.read_value = img_value[b.free_start];
         end
         default: ;
      endcase
   endtask

   function automatic req_beat_type junk_beat(input logic [FUNC_W-1:0] f);
      req_beat_type b;
      b.func = f;
      b.ins_code = CODE_W'($urandom);
      b.ins_value = $urandom;
      b.is_last = 1'($urandom);
      b.free_start = ADDR_W'($urandom);
      b.free_count = COUNT_W'($urandom);
      return b;
   endfunction

   function automatic stim_row_type tab_row(input logic [FUNC_W-1:0] f, input logic [7:0] code,
                                            input logic [31:0] value, input logic last,
                                            input logic [7:0] fstart, input logic [8:0] fcount,
                                            input int lead, input logic typed,
                                            input res_type want);
      stim_row_type row;
      row.beat = '{f, code, value, last, fstart, fcount};
      row.lead = 10'(lead);
      row.typed = typed;
      row.want = want;
      return row;
   endfunction

   function automatic logic [CODE_W-1:0] pick_code();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return model_empty;
      if (r == 1) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return CODE_W'($urandom);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_beat_type read_beat();
      req_beat_type b;
      b = junk_beat(FUNC_READ);
      if ($urandom_range(0, 1)) b.free_start = last_grant + ADDR_W'($urandom_range(0, 7));
      return b;
   endfunction

   task automatic send_beat(input req_beat_type b, input bit typed, input res_type want);
      int gap;
      bit owed;
      res_type r;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= b.func;
      req_bus.ins_code <= b.ins_code;
      req_bus.ins_value <= b.ins_value;
      req_bus.is_last <= b.is_last;
      req_bus.free_start <= b.free_start;
      req_bus.free_count <= b.free_count;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
      cell_image_step(b, owed, r);
      if (owed) rsp_backlog.push_back(typed ? want : r);
   endtask

   task automatic hold_req();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   task automatic drain_responses();
      hold_req();
      while (rsp_backlog.size() != 0) @(posedge clock);
   endtask

   task automatic set_empty_code(input logic [CODE_W-1:0] v);
      drain_responses();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_en <= 1'b0;
      model_empty = v;
      settings++;
   endtask

   // response side ready pattern
   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 16);
         @(negedge clock);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got_rsp = '{rsp_bus.status, rsp_bus.start_address, rsp_bus.read_code,
                     rsp_bus.read_value};
         rsp_checked++;
         if (rsp_backlog.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response beat: status %0d start %0d code %0h value %0d",
                        got_rsp.status, got_rsp.start_address, got_rsp.read_code,
                        got_rsp.read_value);
         end else begin
            want_rsp = rsp_backlog.pop_front();
            if (got_rsp.status !== want_rsp.status ||
                got_rsp.start_address !== want_rsp.start_address ||
                got_rsp.read_code !== want_rsp.read_code ||
                got_rsp.read_value !== want_rsp.read_value) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch on response %0d (exp/act):", rsp_checked);
                  $display("  status %0d/%0d start %0d/%0d code %0h/%0h value %0d/%0d",
                           want_rsp.status, got_rsp.status,
                           want_rsp.start_address, got_rsp.start_address,
                           want_rsp.read_code, got_rsp.read_code,
                           want_rsp.read_value, got_rsp.read_value);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_beat_type b;
      stim_row_type row;
      res_type none;
      int items;
      int len;
      int r;
      logic [CODE_W-1:0] phase_code;

      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.func = FUNC_ALLOC;
      req_bus.ins_code = '0;
      req_bus.ins_value = '0;
      req_bus.is_last = 1'b0;
      req_bus.free_start = '0;
      req_bus.free_count = '0;
      no_idle = 1'b0;
      none = '0;
      model_empty = '0;
      last_grant = '0;
      stage_len = 0;
      idle_cycles = 0;
      for (int i = 0; i < CELLS; i++) begin
         img_code[i] = '0;
         img_value[i] = '0;
      end

      // reset contents, extremes, holes, empty-code content, staging full, clipping
      directed_rows.push_back(tab_row(FUNC_READ, 8'h00, 0, 0, 8'd0, 0, 0, 1,
                                      '{STATUS_OK, 8'd0, 8'h00, 32'sd0}));
      directed_rows.push_back(tab_row(FUNC_READ, 8'hFF, -1, 1, 8'd255, 9'h1FF, 0, 1,
                                      '{STATUS_OK, 8'd0, 8'h00, 32'sd0}));
      directed_rows.push_back(tab_row(FUNC_ALLOC, 8'hFF, 32'h7FFF_FFFF, 1, 0, 0, 0, 1,
                                      '{STATUS_OK, 8'd0, 8'h00, 32'sd0}));
      directed_rows.push_back(tab_row(FUNC_READ, 0, 0, 0, 8'd0, 0, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_ALLOC, 8'h01, 32'h8000_0000, 0, 0, 0, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_ALLOC, 8'h80, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_ALLOC, 8'h7F, 0, 1, 0, 0, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_READ, 0, 0, 0, 8'd2, 0, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_FREE, 0, 0, 0, 8'd1, 9'd1, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_ALLOC, 8'h22, 5, 1, 0, 0, 1, 0, none));
      directed_rows.push_back(tab_row(FUNC_ALLOC, 8'h00, 123, 1, 0, 0, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_READ, 0, 0, 0, 8'd1, 0, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_UNUSED, 8'hFF, -1, 1, 8'hFF, 9'h1FF, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_FREE, 0, 0, 0, 8'd255, 9'd0, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_READ, 0, 0, 0, 8'd255, 0, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_FREE, 0, 0, 0, 8'd0, 9'd256, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_ALLOC, 8'h55, 32'h1234_5678, 1, 0, 0, 257, 1,
                                      '{STATUS_OK, 8'd0, 8'h00, 32'sd0}));
      directed_rows.push_back(tab_row(FUNC_ALLOC, 8'hAA, 7, 1, 0, 0, 0, 1,
                                      '{STATUS_NO_SPACE, 8'd0, 8'h00, 32'sd0}));
      directed_rows.push_back(tab_row(FUNC_READ, 0, 0, 0, 8'd255, 0, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_FREE, 0, 0, 0, 8'd200, 9'd256, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_FREE, 0, 0, 0, 8'd10, 9'd0, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_ALLOC, 8'h66, -77, 1, 0, 0, 55, 0, none));
      directed_rows.push_back(tab_row(FUNC_ALLOC, 8'h67, 1, 1, 0, 0, 1, 0, none));
      directed_rows.push_back(tab_row(FUNC_FREE, 0, 0, 0, 8'd0, 9'h1FF, 0, 0, none));
      directed_rows.push_back(tab_row(FUNC_READ, 0, 0, 0, 8'd128, 0, 0, 1,
                                      '{STATUS_OK, 8'd0, 8'h00, 32'sd0}));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         b = row.beat;
         b.is_last = 1'b0;
         repeat (row.lead) send_beat(b, 1'b0, none);
         send_beat(row.beat, row.typed, row.want);
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: phase_code = 8'hFF;
            2: phase_code = 8'h00;
            default: phase_code = CODE_W'($urandom);
         endcase
         set_empty_code(phase_code);
         items = 0;
         if ($urandom_range(0, 3) != 0) begin
            b = junk_beat(FUNC_FREE);
            b.free_start = 8'd0;
            b.free_count = COUNT_W'($urandom_range(256, 511));
            send_beat(b, 1'b0, none);
            items++;
         end
         while (items < PHASE_ITEMS) begin
            if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
            if ($urandom_range(0, 29) == 0) drain_responses();
            r = $urandom_range(0, 99);
            if (r < 45) begin
               r = $urandom_range(0, 99);
               if (r < 70) len = $urandom_range(1, 6);
               else if (r < 97) len = $urandom_range(7, 40);
               else len = $urandom_range(41, 120);
               for (int k = 0; k < len; k++) begin
                  // stray beats inside an open request
                  if ($urandom_range(0, 7) == 0) begin
                     if ($urandom_range(0, 1)) begin
                        send_beat(read_beat(), 1'b0, none);
                        items++;
                     end else begin
                        send_beat(junk_beat(FUNC_UNUSED), 1'b0, none);
                     end
                  end
                  b = junk_beat(FUNC_ALLOC);
                  b.ins_code = pick_code();
                  b.ins_value = pick_value();
                  b.is_last = (k == len - 1);
                  send_beat(b, 1'b0, none);
                  items++;
               end
            end else if (r < 65) begin
               b = junk_beat(FUNC_FREE);
               if ($urandom_range(0, 1))
                  b.free_start = last_grant + ADDR_W'($urandom_range(0, 3));
               r = $urandom_range(0, 9);
               if (r < 6) b.free_count = COUNT_W'($urandom_range(1, 16));
               else if (r < 8) b.free_count = COUNT_W'($urandom_range(0, 64));
               else if (r < 9) b.free_count = 9'd0;
               else b.free_count = COUNT_W'($urandom_range(200, 511));
               send_beat(b, 1'b0, none);
               items++;
            end else if (r < 92) begin
               send_beat(read_beat(), 1'b0, none);
               items++;
            end else begin
               send_beat(junk_beat(FUNC_UNUSED), 1'b0, none);
            end
         end
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d request beats, %0d responses checked, %0d grants, %0d no-space",
               beats_sent, rsp_checked, grants, no_space);
      $display("empty code written %0d times, including both extremes", settings);
      if (mismatch_count == 0 && rsp_backlog.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
